// ===== rtl/core/fss_pkg.sv =====
// Package for the fuzzy subsequence scorer: sizes, score constants,
// the command opcode type and the classified command carried front to back.
// No dependencies.
`default_nettype none

package fss_pkg;

  localparam int NEEDLE_MAX   = 64;
  localparam int HAYSTACK_MAX = 255;
  localparam int QUEUE_DEPTH  = 2;

  localparam int CHAR_W  = 8;
  localparam int IDX_W   = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
  localparam int LEN_W   = $clog2(NEEDLE_MAX + 1);
  localparam int POS_W   = $clog2(HAYSTACK_MAX + 1);
  localparam int SCORE_W = 15;
  localparam int SUM_W   = SCORE_W + 2;
  localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam int SCORE_EMPTY     = 10000;
  localparam int SCORE_UNMATCHED = -1;
  localparam int START_BONUS     = 100;
  localparam int BOUNDARY_BONUS  = 50;
  localparam int SCORE_MAX       = (1 << (SCORE_W - 1)) - 1;
  localparam int SCORE_MIN       = -(1 << (SCORE_W - 1));

  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_HYPHEN = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_BYTE   = 2'd2,
    OP_END    = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] ch;
    logic              sep;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/fss_front.sv =====
// Front stage: accepts input items, lowercases the character and flags
// separators, and holds the classified command for the queue. Uses fss_pkg.
`default_nettype none

module fss_front import fss_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        opcode_i,
  input  wire logic [CHAR_W-1:0] char_in_i,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_ready_i,
  output cmd_t                   cmd_o
);

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic accept;

  assign in_ready_o = !valid_q || cmd_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_d.op  = op_e'(opcode_i);
    cmd_d.ch  = char_in_i;
    if (char_in_i >= CH_UPPER_A && char_in_i <= CH_UPPER_Z) begin
      cmd_d.ch = char_in_i + CASE_OFFSET;
    end
    cmd_d.sep = (char_in_i == CH_SPACE) || (char_in_i == CH_HYPHEN) ||
                (char_in_i == CH_UNDER);
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

`default_nettype wire

// ===== rtl/core/fss_queue.sv =====
// Short command queue between front and back stages.
// Uses fss_pkg for the command type and depth.
`default_nettype none

module fss_queue import fss_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire cmd_t push_cmd_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output cmd_t      pop_cmd_o
);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fss_back.sv =====
// Back stage: needle store, match cursor, score update and result register.
// Uses fss_pkg for sizes, constants and the command type.
`default_nettype none

module fss_back import fss_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_ready_o,
  input  wire cmd_t              cmd_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   matched_o,
  output logic signed [SCORE_W-1:0] score_o
);

  logic [CHAR_W-1:0] store_q [NEEDLE_MAX];
  logic [CHAR_W-1:0] want_q;

  logic [LEN_W-1:0]   length_q, length_d;
  logic [LEN_W-1:0]   cursor_q, cursor_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [POS_W-1:0]   nexp_q, nexp_d;
  logic [SCORE_W-1:0] run_q, run_d;
  logic               prev_sep_q, prev_sep_d;

  logic                     out_valid_q, out_valid_d;
  logic                     res_matched_q;
  logic signed [SCORE_W-1:0] res_score_q;
  logic                     res_matched_d;
  logic [SCORE_W-1:0]       res_score_d;

  logic              fire, wr_en, hit, done, bypass;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  logic [POS_W-1:0]  gap;
  logic [SUM_W-1:0]  bonus, gap2, sum;

  assign cmd_ready_o = (cmd_i.op != OP_END) || !out_valid_q || out_ready_i;
  assign fire        = cmd_valid_i && cmd_ready_o;

  assign wr_en   = fire && (cmd_i.op == OP_APPEND) && (length_q < LEN_W'(NEEDLE_MAX));
  assign wr_addr = length_q[IDX_W-1:0];
  assign rd_addr = cursor_d[IDX_W-1:0];
  assign bypass  = wr_en && (wr_addr == rd_addr);

  assign done = (cursor_q >= length_q);
  assign hit  = (pos_q < POS_W'(HAYSTACK_MAX)) && !done && (cmd_i.ch == want_q);

  always_comb begin
    gap   = pos_q - nexp_q;
    gap2  = SUM_W'({gap, 1'b0});
    bonus = '0;
    if (pos_q == '0) begin
      bonus = SUM_W'(START_BONUS);
    end else if (prev_sep_q) begin
      bonus = SUM_W'(BOUNDARY_BONUS);
    end
    sum = {{2{run_q[SCORE_W-1]}}, run_q} + bonus - gap2;
  end

  always_comb begin
    length_d   = length_q;
    cursor_d   = cursor_q;
    pos_d      = pos_q;
    nexp_d     = nexp_q;
    run_d      = run_q;
    prev_sep_d = prev_sep_q;
    if (fire) begin
      unique case (cmd_i.op)
        OP_CLEAR: begin
          length_d   = '0;
          cursor_d   = '0;
          pos_d      = '0;
          nexp_d     = '0;
          run_d      = '0;
          prev_sep_d = 1'b0;
        end
        OP_APPEND: begin
          if (wr_en) begin
            length_d = length_q + 1'b1;
          end
        end
        OP_BYTE: begin
          if (pos_q < POS_W'(HAYSTACK_MAX)) begin
            if (hit) begin
              cursor_d = cursor_q + 1'b1;
              nexp_d   = pos_q + 1'b1;
              if ($signed(sum) > $signed(SUM_W'(SCORE_MAX))) begin
                run_d = SCORE_W'(SCORE_MAX);
              end else if ($signed(sum) < $signed(SUM_W'(SCORE_MIN))) begin
                run_d = SCORE_W'(SCORE_MIN);
              end else begin
                run_d = sum[SCORE_W-1:0];
              end
            end
            prev_sep_d = cmd_i.sep;
            pos_d      = pos_q + 1'b1;
          end
        end
        OP_END: begin
          cursor_d   = '0;
          pos_d      = '0;
          nexp_d     = '0;
          run_d      = '0;
          prev_sep_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_matched_d = (length_q == '0) || done;
    if (length_q == '0) begin
      res_score_d = SCORE_W'(SCORE_EMPTY);
    end else if (done) begin
      res_score_d = run_q;
    end else begin
      res_score_d = SCORE_W'(SCORE_UNMATCHED);
    end
    out_valid_d = out_valid_q;
    if (fire && (cmd_i.op == OP_END)) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q    <= '0;
      cursor_q    <= '0;
      pos_q       <= '0;
      nexp_q      <= '0;
      run_q       <= '0;
      prev_sep_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      length_q    <= length_d;
      cursor_q    <= cursor_d;
      pos_q       <= pos_d;
      nexp_q      <= nexp_d;
      run_q       <= run_d;
      prev_sep_q  <= prev_sep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= cmd_i.ch;
    end
    want_q <= bypass ? cmd_i.ch : store_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (fire && (cmd_i.op == OP_END)) begin
      res_matched_q <= res_matched_d;
      res_score_q   <= $signed(res_score_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = res_matched_q;
  assign score_o     = res_score_q;

endmodule

`default_nettype wire

// ===== rtl/core/fuzzy_subsequence_scorer_top.sv =====
// Top level of the fuzzy subsequence scorer: front stage, command queue
// and back stage. Uses fss_pkg, fss_front, fss_queue and fss_back.
//
// Input channel: in_valid_i/in_ready_o with opcode_i and char_in_i.
//   Opcodes clear the needle, append a needle character, feed a haystack
//   byte, or end the haystack. Only the end opcode yields a result.
// Output channel: out_valid_o/out_ready_i with matched_o and score_o.
// Throughput: one item per cycle unless an end item waits on a held
//   result; set by the compare and score update in the back stage
//   against a prefetched needle character.
// Result path: an end item moves from the front register through the
//   queue, and its result is then captured in the result register.
// Receiver stall: the result register holds; non-end items keep flowing
//   into the back stage, and the next end item waits at the queue head,
//   which then fills and drops in_ready_o.
// Reset: needle length, match progress and all handshake state clear;
//   the needle store contents are undefined until appended.
`default_nettype none

module fuzzy_subsequence_scorer_top import fss_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           opcode_i,
  input  wire logic [CHAR_W-1:0]    char_in_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      matched_o,
  output logic signed [SCORE_W-1:0] score_o
);

  logic front_valid, q_push_ready;
  cmd_t front_cmd;
  logic q_valid, back_ready;
  cmd_t q_cmd;

  fss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .char_in_i   (char_in_i),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (q_push_ready),
    .cmd_o       (front_cmd)
  );

  fss_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (q_push_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (back_ready),
    .pop_cmd_o    (q_cmd)
  );

  fss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (q_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .matched_o   (matched_o),
    .score_o     (score_o)
  );

  a_back_stalls_only_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && !back_ready |-> (q_cmd.op == OP_END) && out_valid_o && !out_ready_i)
    else $error("back stage stalled without a blocked result");

  a_front_holds_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_valid && !q_push_ready |=> front_valid)
    else $error("front command lost while queue full");

  a_unmatched_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !matched_o |-> score_o == SCORE_W'(SCORE_UNMATCHED))
    else $error("unmatched result with a score other than minus one");

endmodule

`default_nettype wire
